@@ design/qsoe_pkg.sv @@
// Package for the quoted string octal escaper.
// Holds the character constants and the run type shared by the expander and serialiser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qsoe_pkg;

  // Characters that the escaper emits or tests for.
  localparam logic [7:0] QUOTE_CH     = 8'h22;
  localparam logic [7:0] BACKSLASH_CH = 8'h5C;
  localparam logic [7:0] ZERO_CH      = 8'h30;
  localparam logic [7:0] LOW_PRINT    = 8'h20;
  localparam logic [7:0] HIGH_PRINT   = 8'h7E;

  // Longest output run caused by one input transaction.
  localparam int unsigned RUN_MAX = 6;
  localparam int unsigned RUN_IW  = $clog2(RUN_MAX);

  // One expanded run: the bytes in output order and how many are used.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_IW-1:0]       count;
  } run_t;

endpackage

`default_nettype wire

@@ design/quoted_string_octal_escaper_top.sv @@
// Top level of the quoted string octal escaper: input register, expander and serialiser.
// Depends on qsoe_pkg, qsoe_expand and qsoe_serial.
// The block takes one string byte per input transaction and emits one output byte per
// cycle while out_ready is high, from one to six per input (opening quote, one, two or
// four escaped bytes, closing quote); out_last_of_run marks each input's final byte.
// Throughput is set by the single-byte output port; printable bytes other than quote and
// backslash, not first or last of a string, flow at one input per cycle while out_ready
// is high. Output bytes come from the serialiser's run buffer, loaded from the input
// register, which takes a new input while the serialiser still drains the previous run.
`timescale 1ns / 1ps
`default_nettype none

module quoted_string_octal_escaper_top
  import qsoe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_first_of_string,
  input  wire logic       in_last_of_string,
  input  wire logic       in_empty_string,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;
  logic       first_r;
  logic       last_r;
  logic       empty_r;
  run_t       run;
  logic       run_ready;

  // Input register: refills whenever it is empty or its contents move on.
  assign in_ready = !vld_r || run_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r  <= in_byte;
      first_r <= in_first_of_string;
      last_r  <= in_last_of_string;
      empty_r <= in_empty_string;
    end
  end

  qsoe_expand u_expand (
    .byte_i  (byte_r),
    .first_i (first_r),
    .last_i  (last_r),
    .empty_i (empty_r),
    .run_o   (run)
  );

  qsoe_serial u_serial (
    .clk             (clk),
    .rst_n           (rst_n),
    .run_valid_i     (vld_r),
    .run_i           (run),
    .run_ready_o     (run_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

@@ design/qsoe_expand.sv @@
// Expander: turns one registered input transaction into its run of output bytes.
// Purely combinational; depends on qsoe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qsoe_expand
  import qsoe_pkg::*;
(
  input  wire logic [7:0] byte_i,
  input  wire logic       first_i,
  input  wire logic       last_i,
  input  wire logic       empty_i,
  output run_t            run_o
);

  logic [3:0][7:0]   esc;
  logic [2:0]        esc_len;
  logic [RUN_IW-1:0] pos;
  logic [RUN_IW-1:0] slot;

  // Escaped form of the byte alone.
  always_comb begin
    esc = {4{8'h00}};
    if (byte_i == QUOTE_CH || byte_i == BACKSLASH_CH) begin
      esc[0]  = BACKSLASH_CH;
      esc[1]  = byte_i;
      esc_len = 3'd2;
    end else if (byte_i < LOW_PRINT || byte_i > HIGH_PRINT) begin
      esc[0]  = BACKSLASH_CH;
      esc[1]  = ZERO_CH | {6'd0, byte_i[7:6]};
      esc[2]  = ZERO_CH | {5'd0, byte_i[5:3]};
      esc[3]  = ZERO_CH | {5'd0, byte_i[2:0]};
      esc_len = 3'd4;
    end else begin
      esc[0]  = byte_i;
      esc_len = 3'd1;
    end
  end

  // Place the escaped bytes after an optional opening quote. Every unused
  // slot holds a quote, so a closing quote lands in place by itself.
  always_comb begin
    run_o.bytes = {RUN_MAX{QUOTE_CH}};
    pos         = first_i ? RUN_IW'(1) : RUN_IW'(0);
    slot        = '0;
    if (empty_i) begin
      run_o.count = RUN_IW'(2);
    end else begin
      for (int i = 0; i < 4; i++) begin
        slot = pos + RUN_IW'(i);
        if (3'(i) < esc_len) begin
          run_o.bytes[slot] = esc[i];
        end
      end
      run_o.count = pos + RUN_IW'(esc_len) + (last_i ? RUN_IW'(1) : RUN_IW'(0));
    end
  end

endmodule

`default_nettype wire

@@ design/qsoe_serial.sv @@
// Serialiser: holds one expanded run and hands it out one byte per output transaction.
// Takes the next run in the cycle its last byte is taken; depends on qsoe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qsoe_serial
  import qsoe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       run_valid_i,
  input  run_t            run_i,
  output logic            run_ready_o,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run
);

  run_t              run_r;
  logic              busy_r;
  logic              busy_nxt;
  logic [RUN_IW-1:0] idx_r;
  logic [RUN_IW-1:0] idx_nxt;
  logic              load;

  assign out_valid       = busy_r;
  assign out_byte        = run_r.bytes[idx_r];
  assign out_last_of_run = (idx_r == run_r.count - RUN_IW'(1));

  // A new run may enter when the buffer is empty or its final byte leaves now.
  assign run_ready_o = !busy_r || (out_ready && out_last_of_run);
  assign load        = run_ready_o && run_valid_i;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (busy_r && out_ready) begin
      if (out_last_of_run) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + RUN_IW'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Run buffer.
  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= run_i;
    end
  end

endmodule

`default_nettype wire

@@ design/qsoe_checker.sv @@
// Port-level checker for the quoted string octal escaper, with its bind to the top level.
// Depends on qsoe_pkg and quoted_string_octal_escaper_top.
`timescale 1ns / 1ps
`default_nettype none

module qsoe_checker
  import qsoe_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last_of_run
);

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled output transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last_of_run))
    else $error("stalled output transaction changed");

  // Escaping leaves only printable characters on the output.
  a_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte >= LOW_PRINT && out_byte <= HIGH_PRINT))
    else $error("unprintable byte emitted");

  // A run continues without gaps until its final byte.
  a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid)
    else $error("gap inside an output run");

endmodule

bind quoted_string_octal_escaper_top qsoe_checker u_qsoe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run)
);

`default_nettype wire
